### design/sparse_polynomial_add_merge_unit_defines.svh
// Assertion macros shared by the checker of the sparse polynomial add unit.
// No dependencies; included by the checker file.
`ifndef SPARSE_POLYNOMIAL_ADD_MERGE_UNIT_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADD_MERGE_UNIT_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define SPADD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SPADD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### design/spadd_pkg.sv
// Shared types and constants of the sparse polynomial add unit.
// No dependencies; used by the controller, datapath and top level.
package spadd_pkg;

   localparam int KIND_W = 2;
   localparam int COEF_W = 32;
   localparam int EXP_W  = 16;
   localparam int SUM_W  = 33;
   localparam int TERM_W = COEF_W + EXP_W;

   localparam logic [KIND_W-1:0] KIND_LOAD_FIRST  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_SECOND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START       = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_first;
      logic load_second;
      logic prime;
      logic step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic step_last;
   } status_type;

endpackage

### design/sparse_polynomial_add_merge_unit.sv
// Channel   Direction  Handshake            Contents
// req_      in         req_valid/req_stall  kind, coefficient, exponent
// rsp_      out        rsp_valid/rsp_stall  sum term, last, empty_res, overflow
//
// Loads are accepted back to back while no merge runs. A start transaction
// first reads both list heads, then, while rsp_stall is low, gives one result
// term per compare of the two store read ports, so first_count + second_count
// terms at most, or a single empty term when both lists are empty.
// While a merge runs, req_stall is high; a stalled result holds the merge.
// Reset is synchronous and clears both counts and the pending overflow flag.
//
// Top level of the sparse polynomial add unit; depends on spadd_pkg,
// spadd_ctrl and spadd_dp.
module sparse_polynomial_add_merge_unit #(
   parameter int MAX_TERMS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [spadd_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [spadd_pkg::COEF_W-1:0] req_coefficient,
   input  logic [spadd_pkg::EXP_W-1:0]         req_exponent,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [spadd_pkg::SUM_W-1:0]  rsp_sum_coefficient,
   output logic [spadd_pkg::EXP_W-1:0]         rsp_sum_exponent,
   output logic                                rsp_last,
   output logic                                rsp_empty_res,
   output logic                                rsp_overflow
);

   spadd_pkg::cmd_type    cmd;
   spadd_pkg::status_type status;

   spadd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   spadd_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_coefficient     (req_coefficient),
      .req_exponent        (req_exponent),
      .rsp_stall           (rsp_stall),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_sum_coefficient (rsp_sum_coefficient),
      .rsp_sum_exponent    (rsp_sum_exponent),
      .rsp_last            (rsp_last),
      .rsp_empty_res       (rsp_empty_res),
      .rsp_overflow        (rsp_overflow)
   );

endmodule

### design/spadd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spadd_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/spadd_ctrl.sv
// Controller state machine of the sparse polynomial add unit.
// Depends on spadd_pkg for kind codes and the command and status structs.
module spadd_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [spadd_pkg::KIND_W-1:0]   req_kind,
   input  spadd_pkg::status_type          status,
   output logic                           req_stall,
   output spadd_pkg::cmd_type             cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PRIME = 2'd1;
   localparam logic [1:0] ST_MERGE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;
   logic       is_start;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd.load_first  = 1'b0;
      cmd.load_second = 1'b0;
      cmd.prime       = (state_ff == ST_PRIME);
      cmd.step        = (state_ff == ST_MERGE) && status.out_free;
      is_start        = 1'b0;
      unique case (req_kind)
         spadd_pkg::KIND_LOAD_FIRST:  cmd.load_first  = accept;
         spadd_pkg::KIND_LOAD_SECOND: cmd.load_second = accept;
         spadd_pkg::KIND_START:       is_start        = accept;
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (is_start) state_in = ST_PRIME;
         ST_PRIME: state_in = ST_MERGE;
         ST_MERGE: if (cmd.step && status.step_last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/spadd_dp.sv
// Datapath of the sparse polynomial add unit: term stores, counts, merge
// indices and the result register. Depends on spadd_pkg and spadd_ram.
module spadd_dp #(
   parameter int MAX_TERMS = 32,
   localparam int CNT_W  = $clog2(MAX_TERMS + 1),
   localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spadd_pkg::cmd_type                  cmd,
   input  logic signed [spadd_pkg::COEF_W-1:0] req_coefficient,
   input  logic [spadd_pkg::EXP_W-1:0]         req_exponent,
   input  logic                                rsp_stall,
   output spadd_pkg::status_type               status,
   output logic                                rsp_valid,
   output logic signed [spadd_pkg::SUM_W-1:0]  rsp_sum_coefficient,
   output logic [spadd_pkg::EXP_W-1:0]         rsp_sum_exponent,
   output logic                                rsp_last,
   output logic                                rsp_empty_res,
   output logic                                rsp_overflow
);

   localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_TERMS);

   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0] idx_a_ff, idx_a_in, idx_b_ff, idx_b_in;
   logic [CNT_W-1:0] idx_a_next, idx_b_next;
   logic             dropped_ff, dropped_in;
   logic             full_a, full_b;
   logic             wr_a, wr_b;
   logic [CNT_W-1:0] rd_idx_a, rd_idx_b;

   logic [spadd_pkg::TERM_W-1:0] wr_term, rd_a, rd_b;
   logic [spadd_pkg::EXP_W-1:0]  ea, eb;
   logic [spadd_pkg::SUM_W-1:0]  ca_w, cb_w;
   logic                         a_has, b_has, take_a, take_b;
   logic                         last, empty;
   logic [spadd_pkg::SUM_W-1:0]  coef_sel;
   logic [spadd_pkg::EXP_W-1:0]  exp_sel;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [spadd_pkg::SUM_W-1:0]  coef_ff;
   logic [spadd_pkg::EXP_W-1:0]  exp_ff;
   logic                         last_ff, empty_ff, ovf_ff;

   // Term stores: coefficient in the upper bits, exponent in the lower bits.
   assign full_a  = (cnt_a_ff == FULL);
   assign full_b  = (cnt_b_ff == FULL);
   assign wr_a    = cmd.load_first && !full_a;
   assign wr_b    = cmd.load_second && !full_b;
   assign wr_term = {req_coefficient, req_exponent};

   // Read the head that the next cycle will compare.
   assign rd_idx_a = cmd.prime ? '0 : (cmd.step ? idx_a_next : idx_a_ff);
   assign rd_idx_b = cmd.prime ? '0 : (cmd.step ? idx_b_next : idx_b_ff);

   spadd_ram #(.WIDTH(spadd_pkg::TERM_W), .DEPTH(MAX_TERMS)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[ADDR_W-1:0]),
      .wr_data (wr_term),
      .rd_addr (rd_idx_a[ADDR_W-1:0]),
      .rd_data (rd_a)
   );

   spadd_ram #(.WIDTH(spadd_pkg::TERM_W), .DEPTH(MAX_TERMS)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[ADDR_W-1:0]),
      .wr_data (wr_term),
      .rd_addr (rd_idx_b[ADDR_W-1:0]),
      .rd_data (rd_b)
   );

   assign ea   = rd_a[spadd_pkg::EXP_W-1:0];
   assign eb   = rd_b[spadd_pkg::EXP_W-1:0];
   assign ca_w = {rd_a[spadd_pkg::TERM_W-1], rd_a[spadd_pkg::TERM_W-1:spadd_pkg::EXP_W]};
   assign cb_w = {rd_b[spadd_pkg::TERM_W-1], rd_b[spadd_pkg::TERM_W-1:spadd_pkg::EXP_W]};

   assign a_has = (idx_a_ff < cnt_a_ff);
   assign b_has = (idx_b_ff < cnt_b_ff);

   always_comb begin
      take_a = 1'b0;
      take_b = 1'b0;
      if (a_has && b_has) begin
         if (ea > eb) begin
            take_a = 1'b1;
         end else if (ea < eb) begin
            take_b = 1'b1;
         end else begin
            take_a = 1'b1;
            take_b = 1'b1;
         end
      end else if (a_has) begin
         take_a = 1'b1;
      end else if (b_has) begin
         take_b = 1'b1;
      end
   end

   always_comb begin
      case ({take_a, take_b})
         2'b11:   coef_sel = ca_w + cb_w;
         2'b10:   coef_sel = ca_w;
         2'b01:   coef_sel = cb_w;
         default: coef_sel = '0;
      endcase
   end

   assign exp_sel    = take_a ? ea : (take_b ? eb : '0);
   assign idx_a_next = idx_a_ff + CNT_W'(take_a);
   assign idx_b_next = idx_b_ff + CNT_W'(take_b);
   assign empty      = !a_has && !b_has;
   // With both lists empty the single empty term is also the last one.
   assign last       = !(idx_a_next < cnt_a_ff) && !(idx_b_next < cnt_b_ff);

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.step_last = last;

   always_comb begin
      cnt_a_in   = cnt_a_ff;
      cnt_b_in   = cnt_b_ff;
      dropped_in = dropped_ff;
      if (wr_a) cnt_a_in = cnt_a_ff + CNT_W'(1);
      if (wr_b) cnt_b_in = cnt_b_ff + CNT_W'(1);
      if ((cmd.load_first && full_a) || (cmd.load_second && full_b)) begin
         dropped_in = 1'b1;
      end
      if (cmd.step && last) begin
         cnt_a_in   = '0;
         cnt_b_in   = '0;
         dropped_in = 1'b0;
      end
   end

   assign idx_a_in = cmd.prime ? '0 : (cmd.step ? idx_a_next : idx_a_ff);
   assign idx_b_in = cmd.prime ? '0 : (cmd.step ? idx_b_next : idx_b_ff);

   assign rsp_valid_in = cmd.step || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         dropped_ff   <= 1'b0;
         idx_a_ff     <= '0;
         idx_b_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         dropped_ff   <= dropped_in;
         idx_a_ff     <= idx_a_in;
         idx_b_ff     <= idx_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         coef_ff  <= coef_sel;
         exp_ff   <= exp_sel;
         last_ff  <= last;
         empty_ff <= empty;
         ovf_ff   <= dropped_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sum_coefficient = coef_ff;
   assign rsp_sum_exponent    = exp_ff;
   assign rsp_last            = last_ff;
   assign rsp_empty_res       = empty_ff;
   assign rsp_overflow        = ovf_ff;

endmodule

### design/spadd_chk.sv
// Port-level checker for the sparse polynomial add unit, bound to the top.
// Depends on spadd_pkg and the assertion macros header.
`include "sparse_polynomial_add_merge_unit_defines.svh"

module spadd_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [spadd_pkg::KIND_W-1:0]        req_kind,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [spadd_pkg::SUM_W-1:0]  rsp_sum_coefficient,
   input logic [spadd_pkg::EXP_W-1:0]         rsp_sum_exponent,
   input logic                                rsp_last,
   input logic                                rsp_empty_res
);

   `SPADD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp_valid dropped while stalled")

   `SPADD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_sum_coefficient) && $stable(rsp_sum_exponent), "stalled result changed")

   `SPADD_ASSERT_SAME(a_empty_term, clock, reset, rsp_valid && rsp_empty_res, rsp_last && (rsp_sum_coefficient == '0) && (rsp_sum_exponent == '0), "empty result is not a lone zero term")

   `SPADD_ASSERT_NEXT(a_start_busy, clock, reset, req_valid && !req_stall && (req_kind == spadd_pkg::KIND_START), req_stall, "start transaction did not busy the input")

endmodule

bind sparse_polynomial_add_merge_unit spadd_chk u_spadd_chk (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_kind            (req_kind),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_sum_coefficient (rsp_sum_coefficient),
   .rsp_sum_exponent    (rsp_sum_exponent),
   .rsp_last            (rsp_last),
   .rsp_empty_res       (rsp_empty_res)
);
